// ----- rtl/core/tone_effect_and_song_sequencer_assert.svh -----
// Assertion macros for the tone effect and song sequencer.
// Used by the checker; needs nothing else.
`ifndef TONE_EFFECT_AND_SONG_SEQUENCER_ASSERT_SVH
`define TONE_EFFECT_AND_SONG_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define TESS_AP_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tess: same-cycle check failed");

// next-cycle implication
`define TESS_AP_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tess: next-cycle check failed");

`endif

// ----- rtl/core/tess_pkg.sv -----
// Shared types, constants and the divisor ROM of the tone sequencer.
// No dependencies.
`timescale 1ns / 1ps

package tess_pkg;

	localparam int EFFECT_DEPTH = 512;
	localparam int SONG_LINES   = 1024;
	localparam int NOTE_COUNT   = 96;

	localparam int EPOS_W = $clog2(EFFECT_DEPTH);
	localparam int LINE_W = $clog2(SONG_LINES);
	localparam int NOTE_W = $clog2(NOTE_COUNT);

	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_START_FX = 3'd1;
	localparam logic [2:0] OP_WR_FX    = 3'd2;
	localparam logic [2:0] OP_WR_SONG  = 3'd3;
	localparam logic [2:0] OP_PLAY     = 3'd4;
	localparam logic [2:0] OP_STOP     = 3'd5;
	localparam logic [2:0] OP_RESUME   = 3'd6;

	localparam logic [7:0] END_EFFECT = 8'd99;
	localparam logic [7:0] END_SONG   = 8'd70;
	localparam logic [7:0] SHARP      = 8'd35;
	localparam logic [7:0] DIGIT_ZERO = 8'd48;

	localparam logic [15:0] DIV_ROM [NOTE_COUNT] = '{
		16'd65535, 16'd65535, 16'd65535, 16'd62799, 16'd56818, 16'd54235,
		16'd51877, 16'd49716, 16'd45892, 16'd44192, 16'd41144, 16'd38490,
		16'd36157, 16'd34091, 16'd32248, 16'd30594, 16'd29102, 16'd27118,
		16'd25939, 16'd24351, 16'd22946, 16'd21694, 16'd20572, 16'd19245,
		16'd18357, 16'd17292, 16'd16345, 16'd15297, 16'd14551, 16'd13715,
		16'd12969, 16'd12175, 16'd11473, 16'd10847, 16'd10286, 16'd9701,
		16'd9108,  16'd8584,  16'd8117,  16'd7698,  16'd7231,  16'd6818,
		16'd6450,  16'd6088,  16'd5736,  16'd5424,  16'd5121,  16'd4870,
		16'd4554,  16'd4308,  16'd4058,  16'd3837,  16'd3616,  16'd3419,
		16'd3225,  16'd3044,  16'd2875,  16'd2712,  16'd2560,  16'd2415,
		16'd2281,  16'd2154,  16'd2033,  16'd1918,  16'd1811,  16'd1709,
		16'd1612,  16'd1522,  16'd1436,  16'd1356,  16'd1280,  16'd1208,
		16'd1141,  16'd1076,  16'd1015,  16'd959,   16'd898,   16'd854,
		16'd806,   16'd761,   16'd718,   16'd678,   16'd640,   16'd604,
		16'd570,   16'd538,   16'd508,   16'd479,   16'd452,   16'd427,
		16'd403,   16'd380,   16'd359,   16'd339,   16'd320,   16'd302
	};

	typedef struct packed {
		logic [2:0]  opcode;
		logic [11:0] address;
		logic [7:0]  data;
	} item_t;

	typedef struct packed {
		logic        speaker_on;
		logic [15:0] tone_divisor;
		logic        effect_busy;
		logic        song_stopped;
	} result_t;

	// memory access issued when a beat is taken
	typedef struct packed {
		logic              en;
		logic              fx_we;
		logic              song_we;
		logic [11:0]       address;
		logic [7:0]        data;
		logic [EPOS_W-1:0] fx_pos;
		logic [LINE_W-1:0] line;
	} acc_t;

	typedef struct packed {
		logic [7:0] fx_note;
		logic [7:0] fx_len;
		logic [7:0] song_len;
		logic [7:0] song_letter;
		logic [7:0] song_sustain;
		logic [7:0] song_octave;
	} rd_t;

	function automatic logic [3:0] letter_code(input logic [7:0] letter, input logic sharp);
		logic [3:0] code;
		code = 4'd0;
		unique case (letter)
			"C": code = sharp ? 4'd2 : 4'd1;
			"D": code = sharp ? 4'd4 : 4'd3;
			"E": code = 4'd5;
			"F": code = sharp ? 4'd7 : 4'd6;
			"G": code = sharp ? 4'd9 : 4'd8;
			"A": code = sharp ? 4'd11 : 4'd10;
			"B": code = 4'd12;
			default: code = 4'd0;
		endcase
		return code;
	endfunction

endpackage

// ----- rtl/core/tess_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module tess_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ----- rtl/core/tess_store.sv -----
// Effect memory (two byte banks, even/odd) and song memory (four byte lanes).
// Depends on tess_pkg and tess_ram.
`timescale 1ns / 1ps

module tess_store (
	input  logic           clk,
	input  tess_pkg::acc_t acc,
	output tess_pkg::rd_t  rd
);

	localparam int EB_W = tess_pkg::EPOS_W - 1;
	localparam int LW   = tess_pkg::LINE_W;

	logic [tess_pkg::EPOS_W-1:0] fx_wa;
	logic [LW+1:0]               song_wa;
	logic [EB_W-1:0]             even_ra;
	logic [EB_W-1:0]             even_addr;
	logic [EB_W-1:0]             odd_addr;
	logic [7:0]                  even_rd;
	logic [7:0]                  odd_rd;
	logic                        swap_q;
	logic [7:0]                  lane_rd [4];

	assign fx_wa   = tess_pkg::EPOS_W'(acc.address);
	assign song_wa = (LW+2)'(acc.address);

	// odd start: note in the odd bank, length in the next even word
	assign even_ra   = acc.fx_pos[0] ? acc.fx_pos[tess_pkg::EPOS_W-1:1] + EB_W'(1)
		: acc.fx_pos[tess_pkg::EPOS_W-1:1];
	assign even_addr = acc.fx_we ? fx_wa[tess_pkg::EPOS_W-1:1] : even_ra;
	assign odd_addr  = acc.fx_we ? fx_wa[tess_pkg::EPOS_W-1:1]
		: acc.fx_pos[tess_pkg::EPOS_W-1:1];

	tess_ram #(.WIDTH(8), .DEPTH(tess_pkg::EFFECT_DEPTH / 2)) u_fx_even (
		.clk   (clk),
		.en    (acc.en),
		.we    (acc.fx_we && !fx_wa[0]),
		.addr  (even_addr),
		.wdata (acc.data),
		.rdata (even_rd)
	);

	tess_ram #(.WIDTH(8), .DEPTH(tess_pkg::EFFECT_DEPTH / 2)) u_fx_odd (
		.clk   (clk),
		.en    (acc.en),
		.we    (acc.fx_we && fx_wa[0]),
		.addr  (odd_addr),
		.wdata (acc.data),
		.rdata (odd_rd)
	);

	always_ff @(posedge clk) begin
		if (acc.en) begin
			swap_q <= acc.fx_pos[0];
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_lane
		tess_ram #(.WIDTH(8), .DEPTH(tess_pkg::SONG_LINES)) u_lane (
			.clk   (clk),
			.en    (acc.en),
			.we    (acc.song_we && (song_wa[1:0] == 2'(i))),
			.addr  (acc.song_we ? song_wa[LW+1:2] : acc.line),
			.wdata (acc.data),
			.rdata (lane_rd[i])
		);
	end

	assign rd.fx_note      = swap_q ? odd_rd : even_rd;
	assign rd.fx_len       = swap_q ? even_rd : odd_rd;
	assign rd.song_len     = lane_rd[0];
	assign rd.song_letter  = lane_rd[1];
	assign rd.song_sustain = lane_rd[2];
	assign rd.song_octave  = lane_rd[3];

endmodule

// ----- rtl/core/tess_voice.sv -----
// Voice state registers and the update of the item in the second stage.
// Depends on tess_pkg.
`timescale 1ns / 1ps

module tess_voice (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s1_valid,
	input  logic                          adv,
	input  tess_pkg::item_t               item_s1,
	input  logic                          song_loop,
	input  tess_pkg::rd_t                 rd,
	output logic [tess_pkg::EPOS_W-1:0]   fx_pos,
	output logic [tess_pkg::LINE_W-1:0]   line,
	output tess_pkg::result_t             res
);

	typedef struct packed {
		logic                        effect_on;
		logic                        note_sounding;
		logic [tess_pkg::EPOS_W-1:0] effect_pos;
		logic [8:0]                  note_ticks;
		logic [7:0]                  note_length;
		logic                        song_on;
		logic                        song_ready;
		logic [tess_pkg::LINE_W-1:0] song_line;
		logic [7:0]                  song_ticks;
		logic                        speaker_gate;
		logic [15:0]                 divisor;
	} vstate_t;

	vstate_t    st_q;
	vstate_t    nx;
	logic [7:0] song_len;
	logic [7:0] song_oct;
	logic [3:0] code;
	logic [11:0] sidx;

	assign song_len = rd.song_len - tess_pkg::DIGIT_ZERO;
	assign song_oct = rd.song_octave - tess_pkg::DIGIT_ZERO;
	assign code     = tess_pkg::letter_code(rd.song_letter, rd.song_sustain == tess_pkg::SHARP);
	// (code - 1) + octave * 12
	assign sidx     = {8'd0, code} - 12'd1 + {1'b0, song_oct, 3'b000} + {2'b00, song_oct, 2'b00};

	always_comb begin
		nx = st_q;
		if (s1_valid) begin
			unique case (item_s1.opcode)
				tess_pkg::OP_TICK: begin
					if (nx.effect_on && !nx.note_sounding) begin
						nx.note_length = rd.fx_len;
						if (rd.fx_note == tess_pkg::END_EFFECT) begin
							nx.effect_on    = 1'b0;
							nx.speaker_gate = 1'b0;
						end else begin
							if (rd.fx_note != 8'd0 && rd.fx_note < 8'(tess_pkg::NOTE_COUNT)) begin
								nx.divisor      = tess_pkg::DIV_ROM[rd.fx_note[tess_pkg::NOTE_W-1:0]];
								nx.speaker_gate = 1'b1;
							end else begin
								nx.speaker_gate = 1'b0;
							end
							nx.note_sounding = 1'b1;
						end
					end
					if (nx.effect_on && nx.note_sounding) begin
						nx.note_ticks = nx.note_ticks + 9'd1;
						if (nx.note_ticks > {1'b0, nx.note_length}) begin
							nx.effect_pos    = nx.effect_pos + tess_pkg::EPOS_W'(2);
							nx.note_ticks    = 9'd0;
							nx.note_sounding = 1'b0;
							nx.speaker_gate  = 1'b0;
						end
					end
					if (nx.song_on) begin
						if (nx.song_ticks < song_len) begin
							nx.song_ticks = nx.song_ticks + 8'd1;
						end else begin
							nx.song_ticks = 8'd0;
							nx.song_line  = nx.song_line + tess_pkg::LINE_W'(1);
						end
						if (rd.song_sustain != tess_pkg::END_SONG) begin
							if (!nx.note_sounding) begin
								if (code == 4'd0) begin
									nx.speaker_gate = 1'b0;
								end else if (sidx < 12'(tess_pkg::NOTE_COUNT)) begin
									nx.divisor      = tess_pkg::DIV_ROM[sidx[tess_pkg::NOTE_W-1:0]];
									nx.speaker_gate = 1'b1;
								end else begin
									nx.speaker_gate = 1'b0;
								end
							end
						end else if (song_loop) begin
							nx.song_ticks = 8'd0;
							nx.song_line  = '0;
						end else begin
							nx.song_on      = 1'b0;
							nx.speaker_gate = 1'b0;
						end
					end
				end
				tess_pkg::OP_START_FX: begin
					nx.effect_pos    = tess_pkg::EPOS_W'(item_s1.address);
					nx.note_ticks    = 9'd0;
					nx.note_sounding = 1'b0;
					nx.effect_on     = 1'b1;
				end
				tess_pkg::OP_WR_SONG: begin
					nx.song_ready = 1'b1;
				end
				tess_pkg::OP_PLAY: begin
					if (nx.song_ready) begin
						nx.song_on   = 1'b1;
						nx.song_line = '0;
					end
				end
				tess_pkg::OP_STOP: begin
					nx.song_on      = 1'b0;
					nx.speaker_gate = 1'b0;
				end
				tess_pkg::OP_RESUME: begin
					if (nx.song_ready) begin
						nx.song_on = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= nx;
		end
	end

	// read addresses follow the state as it will be after this edge
	assign fx_pos = nx.effect_pos;
	assign line   = nx.song_line;

	assign res.speaker_on   = nx.speaker_gate;
	assign res.tone_divisor = nx.divisor;
	assign res.effect_busy  = nx.effect_on;
	assign res.song_stopped = !nx.song_on;

endmodule

// ----- rtl/core/tone_effect_and_song_sequencer.sv -----
// Top level of the two-voice tone effect and song sequencer.
// Depends on tess_pkg, tess_store, tess_voice.
`timescale 1ns / 1ps

// One item in, one result out. An item is taken in every cycle as long as
// results are drained; its result is loaded into the output register when the
// second stage advances. The beat cycle reads two effect bytes and one song line
// (four byte lanes) in parallel; the second stage then updates the voices, and the
// read addresses of a following tick are taken from that update. Effect and
// song memory contents are undefined until written; there is no clearing.
// The configuration port (song_loop) is always ready.
module tone_effect_and_song_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  tess_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output tess_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [0:0]        cfg_data
);

	logic                        song_loop_q;
	logic                        s1_valid_q;
	tess_pkg::item_t             item_s1;
	logic                        adv;
	logic                        take;
	tess_pkg::acc_t              acc;
	tess_pkg::rd_t               rd;
	tess_pkg::result_t           res;
	tess_pkg::result_t           result_q;
	logic                        result_valid_q;
	logic [tess_pkg::EPOS_W-1:0] fx_pos;
	logic [tess_pkg::LINE_W-1:0] line;

	assign cfg_ready  = 1'b1;
	assign adv        = s1_valid_q && (!result_valid_q || result_ready);
	assign item_ready = !s1_valid_q || adv;
	assign take       = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			song_loop_q <= 1'b0;
		end else if (cfg_valid) begin
			song_loop_q <= cfg_data[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (take) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
		if (adv) begin
			result_q <= res;
		end
	end

	assign acc.en      = take;
	assign acc.fx_we   = item.opcode == tess_pkg::OP_WR_FX;
	assign acc.song_we = item.opcode == tess_pkg::OP_WR_SONG;
	assign acc.address = item.address;
	assign acc.data    = item.data;
	assign acc.fx_pos  = fx_pos;
	assign acc.line    = line;

	tess_store u_store (
		.clk (clk),
		.acc (acc),
		.rd  (rd)
	);

	tess_voice u_voice (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid_q),
		.adv       (adv),
		.item_s1   (item_s1),
		.song_loop (song_loop_q),
		.rd        (rd),
		.fx_pos    (fx_pos),
		.line      (line),
		.res       (res)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- rtl/core/tess_chk.sv -----
// Port-level checker for the sequencer top level, with its bind.
// Depends on tess_pkg and tone_effect_and_song_sequencer_assert.svh.
`timescale 1ns / 1ps

`include "tone_effect_and_song_sequencer_assert.svh"

module tess_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input tess_pkg::result_t result
);

	logic [1:0] cnt_q;
	logic       in_beat;
	logic       out_beat;
	logic       out_wait;

	assign in_beat  = item_valid && item_ready;
	assign out_beat = result_valid && result_ready;
	assign out_wait = result_valid && !result_ready;

	// items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(in_beat) - 2'(out_beat);
		end
	end

	`TESS_AP_NOW(a_inflight_max, clk, arst_n, 1'b1, cnt_q != 2'd3)
	`TESS_AP_NOW(a_no_invented, clk, arst_n, result_valid, cnt_q != 2'd0)
	`TESS_AP_NEXT(a_empty_no_result, clk, arst_n, cnt_q == 2'd0, !result_valid)
	`TESS_AP_NEXT(a_result_hold, clk, arst_n, out_wait, result_valid && $stable(result))

endmodule

bind tone_effect_and_song_sequencer tess_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for tone_effect_and_song_sequencer. A directed table runs first,
// then random effect programs, songs and noise. A voice model checks each untyped result.
// Depends on tess_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam logic [2:0] OP_NONE = 3'd7;
	localparam int FX_BYTES = 512;
	localparam int TUNE_BYTES = 4096;
	localparam int PITCH_SLOTS = 96;
	localparam bit [7:0] FX_STOP = 8'd99;
	localparam bit [7:0] TUNE_END = "F";
	localparam bit [7:0] SHARP_MARK = "#";
	localparam bit [7:0] ASCII_ZERO = "0";
	localparam int BEAT_TARGET = 1600;
	localparam int PHASES = 8;

	localparam bit [15:0] PITCH_DIV [PITCH_SLOTS] = '{
		16'd65535, 16'd65535, 16'd65535, 16'd62799, 16'd56818, 16'd54235,
		16'd51877, 16'd49716, 16'd45892, 16'd44192, 16'd41144, 16'd38490,
		16'd36157, 16'd34091, 16'd32248, 16'd30594, 16'd29102, 16'd27118,
		16'd25939, 16'd24351, 16'd22946, 16'd21694, 16'd20572, 16'd19245,
		16'd18357, 16'd17292, 16'd16345, 16'd15297, 16'd14551, 16'd13715,
		16'd12969, 16'd12175, 16'd11473, 16'd10847, 16'd10286, 16'd9701,
		16'd9108,  16'd8584,  16'd8117,  16'd7698,  16'd7231,  16'd6818,
		16'd6450,  16'd6088,  16'd5736,  16'd5424,  16'd5121,  16'd4870,
		16'd4554,  16'd4308,  16'd4058,  16'd3837,  16'd3616,  16'd3419,
		16'd3225,  16'd3044,  16'd2875,  16'd2712,  16'd2560,  16'd2415,
		16'd2281,  16'd2154,  16'd2033,  16'd1918,  16'd1811,  16'd1709,
		16'd1612,  16'd1522,  16'd1436,  16'd1356,  16'd1280,  16'd1208,
		16'd1141,  16'd1076,  16'd1015,  16'd959,   16'd898,   16'd854,
		16'd806,   16'd761,   16'd718,   16'd678,   16'd640,   16'd604,
		16'd570,   16'd538,   16'd508,   16'd479,   16'd452,   16'd427,
		16'd403,   16'd380,   16'd359,   16'd339,   16'd320,   16'd302
	};

	typedef struct packed {
		tess_pkg::item_t   it;
		logic              typed;
		tess_pkg::result_t res;
	} row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	tess_pkg::item_t   item_beat = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	tess_pkg::result_t result_beat;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [0:0]        cfg_data = '0;

	// voice model state
	bit [7:0]  fx_mem [FX_BYTES];
	bit        fx_known [FX_BYTES];
	bit [7:0]  tune_mem [TUNE_BYTES];
	bit        tune_known [TUNE_BYTES];
	bit        loop_en, fx_on, fx_holding, tune_on, tune_loaded, gate;
	bit [8:0]  fx_pos, hold_ticks;
	bit [7:0]  hold_len;
	bit [9:0]  tune_line;
	bit [7:0]  tune_ticks;
	bit [15:0] div_latch;

	tess_pkg::result_t voice_status_q [$];
	bit tx_idle, rx_idle;
	int stall_left;
	int n_beats, n_ticks, n_results, n_fail, n_cfg;

	always #2 clk = ~clk;

	tone_effect_and_song_sequencer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item_beat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_beat),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	function automatic logic [11:0] rnd_addr();
		return 12'($urandom_range(0, 4095));
	endfunction

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void set_pitch(int idx);
		if (idx < PITCH_SLOTS) begin
			div_latch = PITCH_DIV[idx];
			gate = 1'b1;
		end else begin
			gate = 1'b0;
		end
	endfunction

	function automatic tess_pkg::result_t advance_voices(tess_pkg::item_t b);
		bit [7:0]          note, len, letter, sustain, octave;
		bit [11:0]         base;
		bit                sharp;
		int                code;
		tess_pkg::result_t r;
		case (b.opcode)
			tess_pkg::OP_TICK: begin
				if (fx_on && !fx_holding) begin
					note = fx_mem[fx_pos];
					hold_len = fx_mem[fx_pos + 9'd1];
					if (note == FX_STOP) begin
						fx_on = 1'b0;
						gate = 1'b0;
					end else begin
						if (note != 8'd0)
							set_pitch(int'(note));
						else
							gate = 1'b0;
						fx_holding = 1'b1;
					end
				end
				if (fx_on && fx_holding) begin
					hold_ticks = hold_ticks + 9'd1;
					if (hold_ticks > hold_len) begin
						fx_pos = fx_pos + 9'd2;
						hold_ticks = '0;
						fx_holding = 1'b0;
						gate = 1'b0;
					end
				end
				if (tune_on) begin
					base = {tune_line, 2'b00};
					len = tune_mem[base] - ASCII_ZERO;
					letter = tune_mem[base + 12'd1];
					sustain = tune_mem[base + 12'd2];
					octave = tune_mem[base + 12'd3] - ASCII_ZERO;
					if (tune_ticks < len) begin
						tune_ticks = tune_ticks + 8'd1;
					end else begin
						tune_ticks = '0;
						tune_line = tune_line + 10'd1;
					end
					if (sustain != TUNE_END) begin
						sharp = (sustain == SHARP_MARK);
						case (letter)
							"C": code = sharp ? 2 : 1;
							"D": code = sharp ? 4 : 3;
							"E": code = 5;
							"F": code = sharp ? 7 : 6;
							"G": code = sharp ? 9 : 8;
							"A": code = sharp ? 11 : 10;
							"B": code = 12;
							default: code = 0;
						endcase
						if (!fx_holding) begin
							if (code == 0)
								gate = 1'b0;
							else
								set_pitch(code - 1 + int'(octave) * 12);
						end
					end else if (loop_en) begin
						tune_ticks = '0;
						tune_line = '0;
					end else begin
						tune_on = 1'b0;
						gate = 1'b0;
					end
				end
			end
			tess_pkg::OP_START_FX: begin
				fx_pos = b.address[8:0];
				hold_ticks = '0;
				fx_holding = 1'b0;
				fx_on = 1'b1;
			end
			tess_pkg::OP_WR_FX: begin
				fx_mem[b.address[8:0]] = b.data;
				fx_known[b.address[8:0]] = 1'b1;
			end
			tess_pkg::OP_WR_SONG: begin
				tune_mem[b.address] = b.data;
				tune_known[b.address] = 1'b1;
				tune_loaded = 1'b1;
			end
			tess_pkg::OP_PLAY: begin
				if (tune_loaded) begin
					tune_on = 1'b1;
					tune_line = '0;
				end
			end
			tess_pkg::OP_STOP: begin
				tune_on = 1'b0;
				gate = 1'b0;
			end
			tess_pkg::OP_RESUME: begin
				if (tune_loaded)
					tune_on = 1'b1;
			end
			default: ;
		endcase
		r.speaker_on = gate;
		r.tone_divisor = div_latch;
		r.effect_busy = fx_on;
		r.song_stopped = !tune_on;
		return r;
	endfunction

	function automatic row_t step_row(logic [2:0] op, logic [11:0] a, logic [7:0] d,
			logic typed = 1'b0, logic sp = 1'b0, logic [15:0] dv = 16'd0,
			logic busy = 1'b0, logic stopped = 1'b1);
		row_t row;
		row.it.opcode = op;
		row.it.address = a;
		row.it.data = d;
		row.typed = typed;
		row.res.speaker_on = sp;
		row.res.tone_divisor = dv;
		row.res.effect_busy = busy;
		row.res.song_stopped = stopped;
		return row;
	endfunction

	task automatic send_beat(logic [2:0] op, logic [11:0] a, logic [7:0] d,
			bit typed = 1'b0, tess_pkg::result_t fixed = '0);
		tess_pkg::item_t   b;
		tess_pkg::result_t r;
		int                gap;
		b.opcode = op;
		b.address = a;
		b.data = d;
		gap = tx_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_beat <= b;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		r = advance_voices(b);
		voice_status_q.push_back(typed ? fixed : r);
		if (op != OP_NONE)
			n_beats++;
		if (op == tess_pkg::OP_TICK)
			n_ticks++;
	endtask

	// a tick never reads memory that was not written: missing bytes get random content first
	task automatic issue(logic [2:0] op, logic [11:0] a, logic [7:0] d,
			bit typed = 1'b0, tess_pkg::result_t fixed = '0);
		bit [8:0]  p;
		bit [2:0]  hi;
		bit [11:0] s;
		bit [7:0]  fill;
		if (op == tess_pkg::OP_TICK) begin
			if (fx_on && !fx_holding) begin
				for (int k = 0; k < 2; k++) begin
					p = 9'(fx_pos + k);
					hi = 3'($urandom_range(0, 7));
					fill = rnd_byte();
					if (!fx_known[p])
						send_beat(tess_pkg::OP_WR_FX, {hi, p}, fill);
				end
			end
			if (tune_on) begin
				for (int k = 0; k < 4; k++) begin
					s = 12'({tune_line, 2'b00} + k);
					fill = rnd_byte();
					if (!tune_known[s])
						send_beat(tess_pkg::OP_WR_SONG, s, fill);
				end
			end
		end
		send_beat(op, a, d, typed, fixed);
	endtask

	task automatic drain_voices();
		item_valid <= 1'b0;
		while (voice_status_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_song_loop(bit v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		loop_en = v;
		n_cfg++;
	endtask

	always @(posedge clk) begin
		tess_pkg::result_t want;
		if (result_valid && result_ready) begin
			n_results++;
			if (voice_status_q.size() == 0) begin
				$error("result beat with nothing pending: %h", result_beat);
				n_fail++;
			end else begin
				want = voice_status_q.pop_front();
				if (result_beat.speaker_on !== want.speaker_on) begin
					$error("speaker_on: expected %0d, got %0d",
						want.speaker_on, result_beat.speaker_on);
					n_fail++;
				end
				if (result_beat.tone_divisor !== want.tone_divisor) begin
					$error("tone_divisor: expected %0d, got %0d",
						want.tone_divisor, result_beat.tone_divisor);
					n_fail++;
				end
				if (result_beat.effect_busy !== want.effect_busy) begin
					$error("effect_busy: expected %0d, got %0d",
						want.effect_busy, result_beat.effect_busy);
					n_fail++;
				end
				if (result_beat.song_stopped !== want.song_stopped) begin
					$error("song_stopped: expected %0d, got %0d",
						want.song_stopped, result_beat.song_stopped);
					n_fail++;
				end
			end
			stall_left = rx_idle ? $urandom_range(0, 9) : 0;
		end else if (stall_left > 0) begin
			stall_left--;
		end
		result_ready <= (stall_left == 0);
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		row_t      rows [24];
		int        n, k, sel, ph;
		bit [11:0] fx_base;
		bit [7:0]  note, len, b0, b1, b2, b3;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_song_loop(1'b0);

		rows = '{
			step_row(tess_pkg::OP_TICK, 12'h000, 8'h00, 1'b1, 1'b0, 16'd0, 1'b0, 1'b1),
			step_row(OP_NONE, 12'hFFF, 8'hFF, 1'b1, 1'b0, 16'd0, 1'b0, 1'b1),
			step_row(tess_pkg::OP_PLAY, 12'h000, 8'h00, 1'b1, 1'b0, 16'd0, 1'b0, 1'b1),
			step_row(tess_pkg::OP_RESUME, 12'h000, 8'h00, 1'b1, 1'b0, 16'd0, 1'b0, 1'b1),
			step_row(tess_pkg::OP_STOP, 12'h000, 8'h00, 1'b1, 1'b0, 16'd0, 1'b0, 1'b1),
			step_row(tess_pkg::OP_WR_FX, 12'hFFF, 8'd95, 1'b1, 1'b0, 16'd0, 1'b0, 1'b1),
			step_row(tess_pkg::OP_WR_FX, 12'h000, 8'd0, 1'b1, 1'b0, 16'd0, 1'b0, 1'b1),
			step_row(tess_pkg::OP_WR_FX, 12'h001, FX_STOP, 1'b1, 1'b0, 16'd0, 1'b0, 1'b1),
			step_row(tess_pkg::OP_WR_FX, 12'h002, 8'd0, 1'b1, 1'b0, 16'd0, 1'b0, 1'b1),
			step_row(tess_pkg::OP_START_FX, 12'hFFF, 8'h00, 1'b1, 1'b0, 16'd0, 1'b1, 1'b1),
			step_row(tess_pkg::OP_TICK,     12'h000, 8'h00),
			step_row(tess_pkg::OP_TICK,     12'h000, 8'h00),
			step_row(tess_pkg::OP_WR_SONG,  12'h000, "0"),
			step_row(tess_pkg::OP_WR_SONG,  12'h001, "G"),
			step_row(tess_pkg::OP_WR_SONG,  12'h002, "#"),
			step_row(tess_pkg::OP_WR_SONG,  12'h003, "7"),
			step_row(tess_pkg::OP_WR_SONG,  12'h004, "0"),
			step_row(tess_pkg::OP_WR_SONG,  12'h005, "A"),
			step_row(tess_pkg::OP_WR_SONG,  12'h006, "F"),
			step_row(tess_pkg::OP_WR_SONG,  12'h007, "0"),
			step_row(tess_pkg::OP_PLAY,     12'h000, 8'h00),
			step_row(tess_pkg::OP_TICK,     12'h000, 8'h00),
			step_row(tess_pkg::OP_TICK,     12'h000, 8'h00),
			step_row(tess_pkg::OP_WR_SONG,  12'hFFF, 8'hFF)
		};
		for (int r = 0; r < 24; r++)
			issue(rows[r].it.opcode, rows[r].it.address, rows[r].it.data,
				rows[r].typed, rows[r].res);

		fx_base = 12'd0;
		for (ph = 0; ph < PHASES; ph++) begin
			drain_voices();
			set_song_loop(ph % 2 == 0);
			tx_idle = (ph % 4) != 3;
			rx_idle = (ph % 4) != 2;
			while (n_beats < BEAT_TARGET * (ph + 1) / PHASES) begin
				sel = $urandom_range(0, 99);
				if (sel < 15) begin
					// effect program ending in the stop code, then played
					fx_base = rnd_addr();
					n = $urandom_range(1, 5);
					for (k = 0; k < n; k++) begin
						b0 = 8'($urandom_range(0, 9));
						if (b0 == 0)
							note = 8'd0;
						else if (b0 == 1)
							note = 8'($urandom_range(96, 255));
						else
							note = 8'($urandom_range(1, 95));
						if ($urandom_range(0, 39) == 0)
							len = rnd_byte();
						else
							len = 8'($urandom_range(0, 3));
						issue(tess_pkg::OP_WR_FX, 12'(fx_base + 2 * k), note);
						issue(tess_pkg::OP_WR_FX, 12'(fx_base + 2 * k + 1), len);
					end
					issue(tess_pkg::OP_WR_FX, 12'(fx_base + 2 * n), FX_STOP);
					issue(tess_pkg::OP_WR_FX, 12'(fx_base + 2 * n + 1), rnd_byte());
					issue(tess_pkg::OP_START_FX, fx_base, rnd_byte());
					repeat ($urandom_range(2, 12))
						issue(tess_pkg::OP_TICK, rnd_addr(), rnd_byte());
				end else if (sel < 27) begin
					// song from line zero with an end line
					n = $urandom_range(1, 6);
					for (k = 0; k <= n; k++) begin
						if ($urandom_range(0, 9) == 0)
							b0 = rnd_byte();
						else
							b0 = 8'(ASCII_ZERO + $urandom_range(0, 3));
						if ($urandom_range(0, 7) == 0)
							b1 = rnd_byte();
						else
							b1 = 8'("A" + $urandom_range(0, 6));
						b3 = 8'($urandom_range(0, 9));
						if (k == n)
							b2 = TUNE_END;
						else if (b3 < 3)
							b2 = SHARP_MARK;
						else if (b3 == 3)
							b2 = rnd_byte();
						else
							b2 = " ";
						if ($urandom_range(0, 9) == 0)
							b3 = rnd_byte();
						else
							b3 = 8'(ASCII_ZERO + $urandom_range(0, 7));
						issue(tess_pkg::OP_WR_SONG, 12'(4 * k), b0);
						issue(tess_pkg::OP_WR_SONG, 12'(4 * k + 1), b1);
						issue(tess_pkg::OP_WR_SONG, 12'(4 * k + 2), b2);
						issue(tess_pkg::OP_WR_SONG, 12'(4 * k + 3), b3);
					end
					issue(tess_pkg::OP_PLAY, rnd_addr(), rnd_byte());
					repeat ($urandom_range(3, 20))
						issue(tess_pkg::OP_TICK, rnd_addr(), rnd_byte());
				end else if (sel < 55) begin
					repeat ($urandom_range(1, 8))
						issue(tess_pkg::OP_TICK, rnd_addr(), rnd_byte());
				end else if (sel < 63) begin
					issue(tess_pkg::OP_START_FX, fx_base, rnd_byte());
					repeat ($urandom_range(1, 6))
						issue(tess_pkg::OP_TICK, rnd_addr(), rnd_byte());
				end else if (sel < 75) begin
					issue(3'($urandom_range(4, 6)), rnd_addr(), rnd_byte());
				end else begin
					issue(3'($urandom_range(0, 7)), rnd_addr(), rnd_byte());
				end
			end
		end

		drain_voices();
		repeat (10) @(posedge clk);
		$display("Sent %0d beats (%0d ticks) in %0d phases, song_loop written %0d times",
			n_beats, n_ticks, PHASES, n_cfg);
		$display("Compared %0d result beats, %0d mismatches", n_results, n_fail);
		if (n_fail == 0 && voice_status_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/tess_pkg.sv
rtl/core/tess_ram.sv
rtl/core/tess_store.sv
rtl/core/tess_voice.sv
rtl/core/tone_effect_and_song_sequencer.sv
rtl/core/tess_chk.sv
tb/sv/tb_top.sv
